// ===== rtl/handle_table_allocator_core_assert.svh =====
// Assertion macros shared by the handle table allocator RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef HANDLE_TABLE_ALLOCATOR_CORE_ASSERT_SVH
`define HANDLE_TABLE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hta_pkg.sv =====
// Types and constants of the handle table allocator.
// No dependencies; used by the controller, the datapath and the top level.
package hta_pkg;

   localparam int TYPE_BITS   = 4;
   localparam int REF_BITS    = 32;
   localparam int HANDLE_BITS = 10;
   localparam int LIMIT_BITS  = 11;
   localparam int ROW_W       = 32;
   localparam int ROW_SHIFT   = 5;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd1024;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_GET = 2'd1;
   localparam logic [1:0] OP_DEL = 2'd2;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_NO_HANDLES = 2'd1;
   localparam logic [1:0] STS_BAD_HANDLE = 2'd2;
   localparam logic [1:0] STS_NULL_ITEM  = 2'd3;

   typedef struct packed {
      logic [1:0]             op;
      logic [HANDLE_BITS-1:0] handle;
      logic [TYPE_BITS-1:0]   item_type;
      logic [REF_BITS-1:0]    item_ref;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] handle_out;
      logic [TYPE_BITS-1:0]   type_out;
      logic [REF_BITS-1:0]    ref_out;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CHECK
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic issue_read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } sts_type;

endpackage

// ===== rtl/hta_ctrl.sv =====
// Sequencer of the handle table allocator: idle, read, check-and-commit.
// Depends on hta_pkg and handle_table_allocator_core_assert.svh.
`include "handle_table_allocator_core_assert.svh"

module hta_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hta_pkg::sts_type sts,
   output hta_pkg::cmd_type cmd
);
   import hta_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.issue_read = 1'b1;
            state_in       = S_CHECK;
         end
         S_CHECK: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `HTA_ASSERT_NOW(a_commit_in_check, cmd.commit, state_ff == S_CHECK, "commit outside check")
   `HTA_ASSERT_NOW(a_commit_slot_free, cmd.commit, sts.rsp_free, "commit with result slot busy")
   `HTA_ASSERT_NEXT(a_accept_to_read, req_valid && !req_stall, state_ff == S_READ,
                    "accepted transaction did not start a read")
   `HTA_ASSERT_NEXT(a_read_to_check, state_ff == S_READ, state_ff == S_CHECK,
                    "read not followed by check")

endmodule

// ===== rtl/hta_datapath.sv =====
// Datapath: used bitmap rows with full flags, entry store, limit register, result register.
// Depends on hta_pkg; driven by hta_ctrl commands.
module hta_datapath #(
   parameter int HANDLE_CAP = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hta_pkg::req_type                  req_data,
   output hta_pkg::rsp_type                  rsp_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              csr_wr_en,
   input  logic [hta_pkg::LIMIT_BITS-1:0]    csr_wr_data,
   input  hta_pkg::cmd_type                  cmd,
   output hta_pkg::sts_type                  sts
);
   import hta_pkg::*;

   localparam int NROWS   = (HANDLE_CAP + ROW_W - 1) / ROW_W;
   localparam int ROWA_W  = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int HIDX_W  = $clog2(HANDLE_CAP);
   localparam int NEWH_W  = ROWA_W + ROW_SHIFT;
   localparam int CAPL_W  = $clog2(HANDLE_CAP + 1);
   localparam int LIM_W   = (CAPL_W > LIMIT_BITS) ? CAPL_W : LIMIT_BITS;
   localparam logic [LIM_W-1:0] CAP_L = LIM_W'(HANDLE_CAP);

   // registers
   logic [LIMIT_BITS-1:0] limit_ff;
   req_type               req_ff;
   logic [ROW_W-1:0]      row_mem [NROWS];
   logic [ROW_W-1:0]      row_rd_ff;
   logic [ROWA_W-1:0]     row_addr_ff;
   logic                  row_found_ff;
   logic [NROWS-1:0]      row_valid_ff, row_valid_in;
   logic [NROWS-1:0]      full_ff, full_in;
   logic [TYPE_BITS-1:0]  type_mem [HANDLE_CAP];
   logic [REF_BITS-1:0]   ref_mem [HANDLE_CAP];
   logic [TYPE_BITS-1:0]  type_rd_ff;
   logic [REF_BITS-1:0]   ref_rd_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // combinational
   logic [LIM_W-1:0]      limit_ext;
   logic [LIM_W-1:0]      eff_lim;
   logic [ROWA_W-1:0]     free_row;
   logic                  free_any;
   logic [ROWA_W-1:0]     rd_row;
   logic [ROW_W-1:0]      cap_mask;
   logic [ROW_W-1:0]      row_eff;
   logic [ROW_SHIFT-1:0]  zero_idx;
   logic                  zero_any;
   logic [NEWH_W-1:0]     h_new;
   logic [ROW_SHIFT-1:0]  bit_idx;
   logic                  used_bit;
   logic                  in_range;
   logic                  row_we;
   logic [ROW_W-1:0]      row_wdata;
   logic                  entry_we;

   assign limit_ext = LIM_W'(limit_ff);
   assign eff_lim   = (limit_ff == '0 || limit_ext > CAP_L) ? CAP_L : limit_ext;

   // lowest row with a free bit
   always_comb begin
      free_row = '0;
      free_any = 1'b0;
      for (int i = NROWS - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            free_row = ROWA_W'(i);
            free_any = 1'b1;
         end
      end
   end

   assign rd_row = (req_ff.op == OP_ADD) ? free_row : ROWA_W'(req_ff.handle >> ROW_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.issue_read) begin
         row_addr_ff  <= rd_row;
         row_found_ff <= free_any;
         row_rd_ff    <= row_mem[rd_row];
         type_rd_ff   <= type_mem[HIDX_W'(req_ff.handle)];
         ref_rd_ff    <= ref_mem[HIDX_W'(req_ff.handle)];
      end
      if (row_we) begin
         row_mem[row_addr_ff] <= row_wdata;
      end
      if (entry_we) begin
         type_mem[HIDX_W'(h_new)] <= req_ff.item_type;
         ref_mem[HIDX_W'(h_new)]  <= req_ff.item_ref;
      end
   end

   // bits beyond the built capacity count as taken
   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         cap_mask[i] = (LIM_W'({row_addr_ff, ROW_SHIFT'(i)}) >= CAP_L);
      end
   end

   assign row_eff = (row_valid_ff[row_addr_ff] ? row_rd_ff : '0) | cap_mask;

   always_comb begin
      zero_idx = '0;
      zero_any = 1'b0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (!row_eff[i]) begin
            zero_idx = ROW_SHIFT'(i);
            zero_any = 1'b1;
         end
      end
   end

   assign h_new    = {row_addr_ff, zero_idx};
   assign bit_idx  = req_ff.handle[ROW_SHIFT-1:0];
   assign used_bit = row_valid_ff[row_addr_ff] && row_rd_ff[bit_idx];
   assign in_range = LIM_W'(req_ff.handle) < eff_lim;

   always_comb begin
      rsp_in       = '0;
      row_we       = 1'b0;
      row_wdata    = row_eff;
      entry_we     = 1'b0;
      row_valid_in = row_valid_ff;
      full_in      = full_ff;
      case (req_ff.op)
         OP_ADD: begin
            if (req_ff.item_ref == '0) begin
               rsp_in.status = STS_NULL_ITEM;
            end else if (!row_found_ff || !zero_any || LIM_W'(h_new) >= eff_lim) begin
               rsp_in.status = STS_NO_HANDLES;
            end else begin
               rsp_in.status     = STS_OK;
               rsp_in.handle_out = HANDLE_BITS'(h_new);
               row_wdata         = row_eff | (ROW_W'(1) << zero_idx);
               row_we            = cmd.commit;
               entry_we          = cmd.commit;
            end
         end
         OP_GET, OP_DEL: begin
            if (in_range && used_bit) begin
               rsp_in.status   = STS_OK;
               rsp_in.type_out = type_rd_ff;
               rsp_in.ref_out  = ref_rd_ff;
               if (req_ff.op == OP_DEL) begin
                  row_wdata = row_eff & ~(ROW_W'(1) << bit_idx);
                  row_we    = cmd.commit;
               end
            end else begin
               rsp_in.status = STS_BAD_HANDLE;
            end
         end
         default: begin
            rsp_in.status = STS_BAD_HANDLE;
         end
      endcase
      if (row_we) begin
         row_valid_in[row_addr_ff] = 1'b1;
         full_in[row_addr_ff]      = &row_wdata;
      end
   end

   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/handle_table_allocator_core.sv =====
// Top level of the handle table allocator: controller plus datapath.
// Depends on hta_pkg, hta_ctrl and hta_datapath.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid / req_stall req_data (hta_pkg::req_type)
//   rsp_     out        rsp_valid / rsp_stall rsp_data (hta_pkg::rsp_type)
//   csr_     in         csr_wr_en             csr_wr_data (handle limit)
//
// A transaction steps through accept, registered read of the bitmap row and
// entry store, then check and commit into the result register; next accept follows.
// A new request is taken only after the last one commits; the row and entry reads are registered.
// Reset clears the row valid bits and full flags; no clearing pass.
// A stalled result holds the next transaction in its check step; one further request
// is taken while the result waits, after which req_stall stays high.
// At most two transactions are held at once: one in the sequencer, one in the result slot.
//
// The used bitmap is held as 32-bit rows. A per-row full flag picks the lowest
// row with a free bit, so add needs only one row read. Rows never written read as
// empty via their valid bit. The type and reference store is written on add only,
// so get and delete return its contents only for handles marked used.
module handle_table_allocator_core #(
   parameter int HANDLE_CAP = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hta_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hta_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [hta_pkg::LIMIT_BITS-1:0] csr_wr_data
);
   import hta_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: one transaction at a time
   hta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, limit register and result slot
   hta_datapath #(
      .HANDLE_CAP (HANDLE_CAP)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
